// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/rri_pkg.sv -----
// Constants and types for the ray against rectangle hit test
`default_nettype none

package rri_pkg;

   localparam int FRAC_BITS     = 10;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_ADDR_LSB  = 3;

   typedef enum logic [2:0] {
      REG_CENTER     = 3'd0,
      REG_NORMAL     = 3'd1,
      REG_RIGHT_AXIS = 3'd2,
      REG_UP_AXIS    = 3'd3,
      REG_HALF_SIZE  = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ray_rectangle_intersection_core.sv -----
// Pipelined ray against oriented rectangle hit test with register port
//
// channel   direction   handshake              payload
// req       in          req_valid/req_ready    origin xyz, dir xyz, reach
// rsp       out         rsp_valid/rsp_ready    hit
// csr       in          psel/penable, pready   paddr, pwdata, prdata
//
// One request a cycle while rsp_ready does not hold the pipeline.
// The restoring divider for the distance takes one quotient bit per stage.
// Every stage holds a valid bit; a stage loads when it is empty or its data moves on.
// Synchronous reset clears the valid bits and the rectangle registers.
// A stalled result holds while earlier stages keep filling their empty slots.
`default_nettype none

`include "assert_macros.svh"

module ray_rectangle_intersection_core
   import rri_pkg::*;
#(
   parameter int COORD_BITS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [COORD_BITS-1:0]    req_origin_x,
   input  logic signed [COORD_BITS-1:0]    req_origin_y,
   input  logic signed [COORD_BITS-1:0]    req_origin_z,
   input  logic signed [COORD_BITS-1:0]    req_dir_x,
   input  logic signed [COORD_BITS-1:0]    req_dir_y,
   input  logic signed [COORD_BITS-1:0]    req_dir_z,
   input  logic        [COORD_BITS-2:0]    req_reach,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic        [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic        [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic        [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int CB = COORD_BITS;
   localparam int QB = CB - 1;
   localparam int OW = CB + 1;
   localparam int PW = 2 * CB + 3;
   localparam int RW = PW + FRAC_BITS + QB;
   localparam int LW = 2 * CB + 2;
   localparam int LO = CB + 1;
   localparam int HW = LW - LO;
   localparam int SW = 2 * CB + 4;
   localparam int XW = 3 * CB + 5;

   localparam int ST_IN  = 0;
   localparam int ST_MUL = 1;
   localparam int ST_SUM = 2;
   localparam int ST_SGN = 3;
   localparam int ST_OVF = 4;
   localparam int ST_T   = ST_OVF + QB + 1;
   localparam int ST_REL = ST_T + 1;
   localparam int ST_PP  = ST_REL + 1;
   localparam int ST_ACC = ST_PP + 1;
   localparam int ST_XY  = ST_ACC + 1;
   localparam int ST_HIT = ST_XY + 1;
   localparam int NS     = ST_HIT + 1;

   // ---------------- registers ----------------
   logic [3*CB-1:0] center_ff, normal_ff, right_ff, up_ff;
   logic [2*CB-1:0] half_ff;
   logic            csr_we;
   csr_index_type   csr_idx;

   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:CSR_ADDR_LSB]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         normal_ff <= '0;
         right_ff  <= '0;
         up_ff     <= '0;
         half_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_CENTER:     center_ff <= csr_pwdata[3*CB-1:0];
            REG_NORMAL:     normal_ff <= csr_pwdata[3*CB-1:0];
            REG_RIGHT_AXIS: right_ff  <= csr_pwdata[3*CB-1:0];
            REG_UP_AXIS:    up_ff     <= csr_pwdata[3*CB-1:0];
            REG_HALF_SIZE:  half_ff   <= csr_pwdata[2*CB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CENTER:     csr_prdata = CSR_DATA_BITS'(center_ff);
         REG_NORMAL:     csr_prdata = CSR_DATA_BITS'(normal_ff);
         REG_RIGHT_AXIS: csr_prdata = CSR_DATA_BITS'(right_ff);
         REG_UP_AXIS:    csr_prdata = CSR_DATA_BITS'(up_ff);
         REG_HALF_SIZE:  csr_prdata = CSR_DATA_BITS'(half_ff);
         default:        csr_prdata = '0;
      endcase
   end

   logic signed [CB-1:0] cfg_c [3];
   logic signed [CB-1:0] cfg_n [3];
   logic signed [CB-1:0] cfg_r [3];
   logic signed [CB-1:0] cfg_u [3];
   logic signed [CB-1:0] cfg_ex, cfg_ey;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cfg_c[i] = $signed(center_ff[i*CB +: CB]);
         cfg_n[i] = $signed(normal_ff[i*CB +: CB]);
         cfg_r[i] = $signed(right_ff[i*CB +: CB]);
         cfg_u[i] = $signed(up_ff[i*CB +: CB]);
      end
      cfg_ex = $signed(half_ff[CB-1:0]);
      cfg_ey = $signed(half_ff[2*CB-1:CB]);
   end

   // ---------------- flow control ----------------
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS:0]   mv;
   logic          in_acc, out_acc;

   assign mv[NS] = rsp_ready;
   for (genvar s = 0; s < NS; s++) begin : g_mv
      assign mv[s] = !v_ff[s] || mv[s+1];
   end

   assign req_ready = mv[ST_IN];
   assign rsp_valid = v_ff[ST_HIT];
   assign in_acc    = req_valid && req_ready;
   assign out_acc   = rsp_valid && rsp_ready;

   always_comb begin
      for (int s = 0; s < NS; s++) begin
         if (mv[s]) begin
            v_in[s] = (s == 0) ? req_valid : v_ff[(s == 0) ? 0 : s - 1];
         end else begin
            v_in[s] = v_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // ---------------- input stage ----------------
   logic signed [CB-1:0] req_o [3];
   logic signed [CB-1:0] req_d [3];
   logic signed [OW-1:0] s0_oc_ff [3];
   logic signed [CB-1:0] s0_d_ff [3];
   logic        [QB-1:0] s0_reach_ff;
   logic                 s0_dz_ff;

   assign req_o[0] = req_origin_x;
   assign req_o[1] = req_origin_y;
   assign req_o[2] = req_origin_z;
   assign req_d[0] = req_dir_x;
   assign req_d[1] = req_dir_y;
   assign req_d[2] = req_dir_z;

   always_ff @(posedge clock) begin
      if (mv[ST_IN]) begin
         for (int i = 0; i < 3; i++) begin
            s0_oc_ff[i] <= cfg_c[i] - req_o[i];
            s0_d_ff[i]  <= req_d[i];
         end
         s0_reach_ff <= req_reach;
         s0_dz_ff    <= (req_dir_x == '0) && (req_dir_y == '0) && (req_dir_z == '0);
      end
   end

   // ---------------- plane products ----------------
   logic signed [2*CB:0]   s1_qp_ff [3];
   logic signed [2*CB-1:0] s1_dp_ff [3];
   logic signed [OW-1:0]   s1_oc_ff [3];
   logic signed [CB-1:0]   s1_d_ff [3];
   logic        [QB-1:0]   s1_reach_ff;
   logic                   s1_dz_ff;

   always_ff @(posedge clock) begin
      if (mv[ST_MUL]) begin
         for (int i = 0; i < 3; i++) begin
            s1_qp_ff[i] <= s0_oc_ff[i] * cfg_n[i];
            s1_dp_ff[i] <= s0_d_ff[i] * cfg_n[i];
            s1_oc_ff[i] <= s0_oc_ff[i];
            s1_d_ff[i]  <= s0_d_ff[i];
         end
         s1_reach_ff <= s0_reach_ff;
         s1_dz_ff    <= s0_dz_ff;
      end
   end

   // ---------------- plane sums ----------------
   logic signed [PW-1:0] s2_qn_ff, s2_dn_ff;
   logic signed [OW-1:0] s2_oc_ff [3];
   logic signed [CB-1:0] s2_d_ff [3];
   logic        [QB-1:0] s2_reach_ff;
   logic                 s2_dz_ff;

   always_ff @(posedge clock) begin
      if (mv[ST_SUM]) begin
         s2_qn_ff    <= s1_qp_ff[0] + s1_qp_ff[1] + s1_qp_ff[2];
         s2_dn_ff    <= s1_dp_ff[0] + s1_dp_ff[1] + s1_dp_ff[2];
         s2_oc_ff    <= s1_oc_ff;
         s2_d_ff     <= s1_d_ff;
         s2_reach_ff <= s1_reach_ff;
         s2_dz_ff    <= s1_dz_ff;
      end
   end

   // ---------------- sign and magnitude ----------------
   logic [PW-1:0]        s3_qmag_in, s3_dmag_in;
   logic                 s3_miss_in;
   logic [RW-1:0]        s3_num_ff, s3_den_ff;
   logic                 s3_miss_ff, s3_par_ff;
   logic signed [OW-1:0] s3_oc_ff [3];
   logic signed [CB-1:0] s3_d_ff [3];
   logic        [QB-1:0] s3_reach_ff;

   always_comb begin
      s3_qmag_in = s2_qn_ff[PW-1] ? PW'(-s2_qn_ff) : PW'(s2_qn_ff);
      s3_dmag_in = s2_dn_ff[PW-1] ? PW'(-s2_dn_ff) : PW'(s2_dn_ff);
      if (s2_dn_ff == '0) begin
         s3_miss_in = s2_dz_ff || (s2_qn_ff != '0);
      end else begin
         s3_miss_in = (s2_qn_ff != '0) && (s2_qn_ff[PW-1] != s2_dn_ff[PW-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (mv[ST_SGN]) begin
         s3_num_ff   <= RW'(s3_qmag_in) << FRAC_BITS;
         s3_den_ff   <= RW'(s3_dmag_in);
         s3_miss_ff  <= s3_miss_in;
         s3_par_ff   <= (s2_dn_ff == '0);
         s3_oc_ff    <= s2_oc_ff;
         s3_d_ff     <= s2_d_ff;
         s3_reach_ff <= s2_reach_ff;
      end
   end

   // ---------------- distance divider ----------------
   logic [RW-1:0]        dv_rem_ff   [QB+1];
   logic [RW-1:0]        dv_den_ff   [QB+1];
   logic [QB-1:0]        dv_q_ff     [QB+1];
   logic                 dv_sat_ff   [QB+1];
   logic                 dv_par_ff   [QB+1];
   logic                 dv_miss_ff  [QB+1];
   logic signed [OW-1:0] dv_oc_ff    [QB+1][3];
   logic signed [CB-1:0] dv_d_ff     [QB+1][3];
   logic        [QB-1:0] dv_reach_ff [QB+1];

   always_ff @(posedge clock) begin
      if (mv[ST_OVF]) begin
         dv_rem_ff[0]   <= s3_num_ff;
         dv_den_ff[0]   <= s3_den_ff;
         dv_q_ff[0]     <= '0;
         dv_sat_ff[0]   <= s3_num_ff >= (s3_den_ff << QB);
         dv_par_ff[0]   <= s3_par_ff;
         dv_miss_ff[0]  <= s3_miss_ff;
         dv_oc_ff[0]    <= s3_oc_ff;
         dv_d_ff[0]     <= s3_d_ff;
         dv_reach_ff[0] <= s3_reach_ff;
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_div
      logic [RW-1:0] dv_sub;
      logic          dv_ge;
      logic [RW-1:0] dv_rem_in;
      logic [QB-1:0] dv_q_in;

      always_comb begin
         dv_sub    = dv_den_ff[j-1] << (QB - j);
         dv_ge     = dv_rem_ff[j-1] >= dv_sub;
         dv_rem_in = dv_ge ? dv_rem_ff[j-1] - dv_sub : dv_rem_ff[j-1];
         dv_q_in   = dv_q_ff[j-1];
         dv_q_in[QB-j] = dv_ge;
      end

      always_ff @(posedge clock) begin
         if (mv[ST_OVF + j]) begin
            dv_rem_ff[j]   <= dv_rem_in;
            dv_den_ff[j]   <= dv_den_ff[j-1];
            dv_q_ff[j]     <= dv_q_in;
            dv_sat_ff[j]   <= dv_sat_ff[j-1];
            dv_par_ff[j]   <= dv_par_ff[j-1];
            dv_miss_ff[j]  <= dv_miss_ff[j-1];
            dv_oc_ff[j]    <= dv_oc_ff[j-1];
            dv_d_ff[j]     <= dv_d_ff[j-1];
            dv_reach_ff[j] <= dv_reach_ff[j-1];
         end
      end
   end

   // ---------------- distance select ----------------
   logic [QB-1:0]        t_in;
   logic [QB-1:0]        t_ff, t_reach_ff;
   logic                 t_miss_ff;
   logic signed [OW-1:0] t_oc_ff [3];
   logic signed [CB-1:0] t_d_ff [3];

   always_comb begin
      if (dv_par_ff[QB]) begin
         t_in = '0;
      end else if (dv_sat_ff[QB]) begin
         t_in = '1;
      end else begin
         t_in = dv_q_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (mv[ST_T]) begin
         t_ff       <= t_in;
         t_reach_ff <= dv_reach_ff[QB];
         t_miss_ff  <= dv_miss_ff[QB] || (t_in > dv_reach_ff[QB]);
         t_oc_ff    <= dv_oc_ff[QB];
         t_d_ff     <= dv_d_ff[QB];
      end
   end

   // ---------------- hit point relative to centre ----------------
   logic signed [LW-1:0] rel_ff [3];
   logic                 rel_miss_ff;

   always_ff @(posedge clock) begin
      if (mv[ST_REL]) begin
         for (int i = 0; i < 3; i++) begin
            rel_ff[i] <= $signed({1'b0, t_ff}) * t_d_ff[i] - (t_oc_ff[i] <<< FRAC_BITS);
         end
         rel_miss_ff <= t_miss_ff;
      end
   end

   // ---------------- axis partial products ----------------
   logic signed [LO+CB:0]   pp_xl_ff [3];
   logic signed [HW+CB-1:0] pp_xh_ff [3];
   logic signed [LO+CB:0]   pp_yl_ff [3];
   logic signed [HW+CB-1:0] pp_yh_ff [3];
   logic                    pp_miss_ff;

   always_ff @(posedge clock) begin
      if (mv[ST_PP]) begin
         for (int i = 0; i < 3; i++) begin
            pp_xl_ff[i] <= $signed({1'b0, rel_ff[i][LO-1:0]}) * cfg_r[i];
            pp_xh_ff[i] <= $signed(rel_ff[i][LW-1:LO]) * cfg_r[i];
            pp_yl_ff[i] <= $signed({1'b0, rel_ff[i][LO-1:0]}) * cfg_u[i];
            pp_yh_ff[i] <= $signed(rel_ff[i][LW-1:LO]) * cfg_u[i];
         end
         pp_miss_ff <= rel_miss_ff;
      end
   end

   // ---------------- partial sums ----------------
   logic signed [SW-1:0] acc_xl_ff, acc_xh_ff, acc_yl_ff, acc_yh_ff;
   logic                 acc_miss_ff;

   always_ff @(posedge clock) begin
      if (mv[ST_ACC]) begin
         acc_xl_ff   <= pp_xl_ff[0] + pp_xl_ff[1] + pp_xl_ff[2];
         acc_xh_ff   <= pp_xh_ff[0] + pp_xh_ff[1] + pp_xh_ff[2];
         acc_yl_ff   <= pp_yl_ff[0] + pp_yl_ff[1] + pp_yl_ff[2];
         acc_yh_ff   <= pp_yh_ff[0] + pp_yh_ff[1] + pp_yh_ff[2];
         acc_miss_ff <= pp_miss_ff;
      end
   end

   // ---------------- projections ----------------
   logic signed [XW-1:0] xy_x_ff, xy_y_ff;
   logic                 xy_miss_ff;

   always_ff @(posedge clock) begin
      if (mv[ST_XY]) begin
         xy_x_ff    <= (acc_xh_ff <<< LO) + acc_xl_ff;
         xy_y_ff    <= (acc_yh_ff <<< LO) + acc_yl_ff;
         xy_miss_ff <= acc_miss_ff;
      end
   end

   // ---------------- extent test ----------------
   logic signed [XW-1:0] lim_x, lim_y;
   logic                 hit_in;
   logic                 rsp_hit_ff;

   always_comb begin
      lim_x  = cfg_ex;
      lim_y  = cfg_ey;
      lim_x  = lim_x <<< (2 * FRAC_BITS);
      lim_y  = lim_y <<< (2 * FRAC_BITS);
      hit_in = !xy_miss_ff && (xy_x_ff >= -lim_x) && (xy_x_ff <= lim_x)
               && (xy_y_ff >= -lim_y) && (xy_y_ff <= lim_y);
   end

   always_ff @(posedge clock) begin
      if (mv[ST_HIT]) begin
         rsp_hit_ff <= hit_in;
      end
   end

   assign rsp_hit = rsp_hit_ff;

   // ---------------- checks ----------------
   `ASSERT_CLK(a_occupancy, clock, reset, 1'b1 |=> ($countones(v_ff) == $countones($past(v_ff)) + $past(in_acc) - $past(out_acc)), "pipeline occupancy out of step with handshakes")
   `ASSERT_CLK(a_reach_miss, clock, reset, v_ff[ST_T] && (t_ff > t_reach_ff) |-> t_miss_ff, "distance beyond reach not marked as miss")
   `ASSERT_NEVER(a_div_rem, clock, reset, v_ff[ST_T-1] && !dv_sat_ff[QB] && !dv_par_ff[QB] && (dv_rem_ff[QB] >= dv_den_ff[QB]), "divider remainder not below divisor")

endmodule

`default_nettype wire
